### src/rwc_pkg.sv
// Shared constants and CRC helper functions for the rounded word CRC-32 block.
package rwc_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CRC_W   = 32;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned VEC_W   = CRC_W + WORD_W;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  // Request layout on the input stream
  localparam int unsigned IN_DATA_W = WORD_W + CRC_W;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned USER_PRESENT = 0;
  localparam int unsigned USER_FIRST   = 1;

  // Fold a 64-bit word into the reflected CRC, least significant bit first.
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                input logic [WORD_W-1:0] word);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int b = 0; b < WORD_W; b++) begin
      fb = c[0] ^ word[b];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Column of the XOR network for result bit j over {word, crc}.
  function automatic logic [VEC_W-1:0] crc_col(input int unsigned j);
    logic [VEC_W-1:0]  col;
    logic [VEC_W-1:0]  unit;
    logic [CRC_W-1:0]  c;
    col = '0;
    for (int i = 0; i < VEC_W; i++) begin
      unit   = VEC_W'(1) << i;
      c      = crc_fold(unit[CRC_W-1:0], unit[VEC_W-1:CRC_W]);
      col[i] = c[j];
    end
    return col;
  endfunction

endpackage

### src/rounded_word_crc32.sv
// Top level: rounding of 64-bit words and a reflected CRC-32 fold.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata {init_crc, data_bits}, tuser, tlast=last_item
//  out_    | out | out_tvalid/out_tready| tdata crc_value
//  cfg_    | in  | cfg_we               | cfg_wdata clear_bits
//
// One request per cycle is taken unless a last request waits on a full result register.
// The rounding add sits in the input stage, the 64-bit XOR network in the fold stage.
// Reset clears clear_bits, the CRC register and all valid flags.
// A full result register that is not taken holds the fold stage only when it carries a
// last request; other requests keep flowing.
module rounded_word_crc32 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rwc_pkg::IN_DATA_W-1:0] in_tdata,  // data_bits[63:0], init_crc[95:64]
  input  logic [rwc_pkg::IN_USER_W-1:0] in_tuser,  // word_present[0], first_item[1]
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rwc_pkg::CRC_W-1:0]     out_tdata, // crc_value[31:0]
  input  logic                          cfg_we,
  input  logic [rwc_pkg::SHIFT_W-1:0]   cfg_wdata
);
  import rwc_pkg::*;

  logic [SHIFT_W-1:0] clear_bits_r;

  logic               s1_valid_r;
  logic [WORD_W-1:0]  s1_word_r;
  logic [CRC_W-1:0]   s1_init_r;
  logic               s1_present_r;
  logic               s1_first_r;
  logic               s1_last_r;

  logic [CRC_W-1:0]   crc_r;
  logic [CRC_W-1:0]   crc_nxt;
  logic               out_valid_r;
  logic [CRC_W-1:0]   out_data_r;

  logic               in_fire;
  logic               out_free;
  logic               s1_retire;
  logic [WORD_W-1:0]  half;
  logic [WORD_W-1:0]  keep_mask;
  logic [WORD_W-1:0]  rounded;
  logic [CRC_W-1:0]   crc_cur;
  logic [VEC_W-1:0]   fold_vec;
  logic [CRC_W-1:0]   crc_folded;
  logic [CRC_W-1:0]   crc_upd;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_retire = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_retire;
  assign in_fire   = in_tvalid && in_tready;

  // Round half up at the lowest kept bit, then drop the cleared bits
  assign half      = (WORD_W'(1) << clear_bits_r) >> 1;
  assign keep_mask = {WORD_W{1'b1}} << clear_bits_r;
  assign rounded   = (in_tdata[WORD_W-1:0] + half) & keep_mask;

  assign crc_cur  = s1_first_r ? s1_init_r : crc_r;
  assign fold_vec = {s1_word_r, crc_cur};

  for (genvar j = 0; j < CRC_W; j++) begin : g_fold
    localparam logic [VEC_W-1:0] COL = crc_col(j);
    assign crc_folded[j] = ^(fold_vec & COL);
  end

  assign crc_upd = s1_present_r ? crc_folded : crc_cur;
  assign crc_nxt = s1_last_r ? ~crc_upd : crc_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_bits_r <= '0;
    end else if (cfg_we) begin
      clear_bits_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r    <= rounded;
      s1_init_r    <= in_tdata[IN_DATA_W-1:WORD_W];
      s1_present_r <= in_tuser[USER_PRESENT];
      s1_first_r   <= in_tuser[USER_FIRST];
      s1_last_r    <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else if (s1_retire) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_retire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire && s1_last_r) begin
      out_data_r <= crc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### src/rwc_checker.sv
// Port-level checks for the rounded word CRC-32 block, bound to the top level.
module rwc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rwc_pkg::CRC_W-1:0]     out_tdata
);
  import rwc_pkg::*;

  // Drop any pending result on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result pending or input blocked after reset");

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A refused request only ever comes with a full, stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused without a stalled result");

endmodule

bind rounded_word_crc32 rwc_checker u_rwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
